// ----- rtl/bmfc_pkg.sv -----
// package with constants, types and field layout for the banked memory fill and copy engine
`default_nettype none
package bmfc_pkg;

  localparam int unsigned BANK_COUNT = 16;
  localparam int unsigned BANK_BYTES = 65536;
  localparam int unsigned ADDR_W     = $clog2(BANK_BYTES);
  localparam int unsigned BANK_SEL_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HDR_BYTES  = 11;
  localparam int unsigned IDX_W      = 4;

  // input word layout
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned ITEM_BANK_W = 4;
  localparam int unsigned OPCODE_LSB = 0;
  localparam int unsigned BANK_LSB   = OPCODE_LSB + OPCODE_W;
  localparam int unsigned ADDR_LSB   = BANK_LSB + ITEM_BANK_W;
  localparam int unsigned WDATA_LSB  = ADDR_LSB + ADDR_W;
  localparam int unsigned IN_USED_W  = WDATA_LSB + BYTE_W;
  localparam int unsigned IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // output word layout
  localparam int unsigned OUT_USED_W  = BYTE_W + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // command block byte offsets
  localparam int unsigned HDR_OP   = 0;
  localparam int unsigned HDR_LEN  = 1;
  localparam int unsigned HDR_W3   = 3;
  localparam int unsigned HDR_W5   = 5;
  localparam int unsigned HDR_W7   = 7;
  localparam int unsigned HDR_W9   = 9;

  localparam logic [BYTE_W-1:0] CMD_FILL     = 8'd0;
  localparam logic [BYTE_W-1:0] CMD_COPY_FWD = 8'd1;
  localparam logic [BYTE_W-1:0] CMD_COPY_BWD = 8'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OPC_WRITE = 2'd0,
    OPC_READ  = 2'd1,
    OPC_RUN   = 2'd2,
    OPC_NONE  = 2'd3
  } item_op_e;

  typedef enum logic [1:0] {
    OPK_FILL,
    OPK_FWD,
    OPK_BWD,
    OPK_BAD
  } op_kind_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_ITEM_WR,
    ACC_ITEM_RD,
    ACC_FETCH,
    ACC_FILL_WR,
    ACC_SRC_RD,
    ACC_DST_WR,
    ACC_CLEAR
  } acc_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_DISPATCH,
    S_FILL,
    S_CP_RD,
    S_CP_WR,
    S_FINISH
  } state_e;

  typedef struct packed {
    acc_e acc;
    logic item_ld;
    logic fetch_clr;
    logic walk_init;
    logic walk_step;
    logic res_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic     clr_last;
    logic     fetch_last;
    logic     rem_zero;
    op_kind_e op_kind;
    item_op_e item_op;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ----- rtl/bmfc_ram.sv -----
// generic single-port ram with registered read
`default_nettype none
module bmfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/bmfc_datapath.sv -----
// datapath: memory banks, item and command block registers, walk counters, result register
`default_nettype none
module bmfc_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bmfc_pkg::ctrl_cmd_t                cmd_i,
  output bmfc_pkg::ctrl_sts_t                     sts_o,
  input  wire logic [bmfc_pkg::IN_TDATA_W-1:0]    item_i,
  output logic      [bmfc_pkg::BYTE_W-1:0]        read_data_o,
  output logic                                    bad_command_o
);

  localparam int unsigned AW = bmfc_pkg::ADDR_W;
  localparam int unsigned BW = bmfc_pkg::BYTE_W;
  localparam int unsigned WW = bmfc_pkg::WORD_W;
  localparam int unsigned SW = bmfc_pkg::BANK_SEL_W;

  // item registers
  logic [bmfc_pkg::OPCODE_W-1:0]    op_q;
  logic [bmfc_pkg::ITEM_BANK_W-1:0] bank_q;
  logic [AW-1:0]                    addr_q;
  logic [BW-1:0]                    wdata_q;

  // command block and walk state
  logic [BW-1:0]        hdr_q [bmfc_pkg::HDR_BYTES];
  logic [bmfc_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [AW-1:0]        off_q, off_d;
  logic [WW-1:0]        rem_q, rem_d;
  logic [AW-1:0]        clr_q, clr_d;

  // read tracking
  logic          rd_ok_q;
  logic [SW-1:0] rd_sel_q;

  logic [BW-1:0] rdata_raw [bmfc_pkg::BANK_COUNT];
  logic [BW-1:0] rdata;

  logic [WW-1:0] len, w3, w5, w7, w9;
  bmfc_pkg::op_kind_e op_kind;

  // memory request
  logic          m_en, m_we, m_all;
  logic [WW-1:0] m_bank;
  logic [AW-1:0] m_addr;
  logic [BW-1:0] m_wdata;
  logic          m_bank_ok;
  logic [SW-1:0] m_sel;

  logic [BW-1:0]  res_data_q;
  logic           res_bad_q;

  assign len = {hdr_q[bmfc_pkg::HDR_LEN], hdr_q[bmfc_pkg::HDR_LEN + 1]};
  assign w3  = {hdr_q[bmfc_pkg::HDR_W3], hdr_q[bmfc_pkg::HDR_W3 + 1]};
  assign w5  = {hdr_q[bmfc_pkg::HDR_W5], hdr_q[bmfc_pkg::HDR_W5 + 1]};
  assign w7  = {hdr_q[bmfc_pkg::HDR_W7], hdr_q[bmfc_pkg::HDR_W7 + 1]};
  assign w9  = {hdr_q[bmfc_pkg::HDR_W9], hdr_q[bmfc_pkg::HDR_W9 + 1]};

  always_comb begin
    priority if (hdr_q[bmfc_pkg::HDR_OP] == bmfc_pkg::CMD_FILL) begin
      op_kind = bmfc_pkg::OPK_FILL;
    end else if (hdr_q[bmfc_pkg::HDR_OP] == bmfc_pkg::CMD_COPY_FWD) begin
      op_kind = bmfc_pkg::OPK_FWD;
    end else if (hdr_q[bmfc_pkg::HDR_OP] == bmfc_pkg::CMD_COPY_BWD) begin
      op_kind = bmfc_pkg::OPK_BWD;
    end else begin
      op_kind = bmfc_pkg::OPK_BAD;
    end
  end

  assign rdata = rd_ok_q ? rdata_raw[rd_sel_q] : '0;

  always_comb begin
    m_en    = 1'b0;
    m_we    = 1'b0;
    m_all   = 1'b0;
    m_bank  = '0;
    m_addr  = '0;
    m_wdata = '0;
    unique case (cmd_i.acc)
      bmfc_pkg::ACC_NONE: begin
      end
      bmfc_pkg::ACC_ITEM_WR: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_bank  = WW'(bank_q);
        m_addr  = addr_q;
        m_wdata = wdata_q;
      end
      bmfc_pkg::ACC_ITEM_RD: begin
        m_en   = 1'b1;
        m_bank = WW'(bank_q);
        m_addr = addr_q;
      end
      bmfc_pkg::ACC_FETCH: begin
        m_en   = (idx_q < bmfc_pkg::IDX_W'(bmfc_pkg::HDR_BYTES));
        m_addr = addr_q + AW'(idx_q);
      end
      bmfc_pkg::ACC_FILL_WR: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_bank  = w3;
        m_addr  = w5 + off_q;
        m_wdata = hdr_q[bmfc_pkg::HDR_W7];
      end
      bmfc_pkg::ACC_SRC_RD: begin
        m_en   = 1'b1;
        m_bank = w3;
        m_addr = w5 + off_q;
      end
      bmfc_pkg::ACC_DST_WR: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_bank  = w7;
        m_addr  = w9 + off_q;
        m_wdata = rdata;
      end
      bmfc_pkg::ACC_CLEAR: begin
        m_en   = 1'b1;
        m_we   = 1'b1;
        m_all  = 1'b1;
        m_addr = clr_q;
      end
      default: begin
      end
    endcase
  end

  assign m_bank_ok = (m_bank < WW'(bmfc_pkg::BANK_COUNT));
  assign m_sel     = m_bank[SW-1:0];

  for (genvar b = 0; b < bmfc_pkg::BANK_COUNT; b++) begin : g_bank
    logic bank_en;
    assign bank_en = m_en && (m_all || (m_bank_ok && (m_sel == SW'(b))));
    bmfc_ram #(
      .WIDTH(BW),
      .DEPTH(bmfc_pkg::BANK_BYTES)
    ) u_ram (
      .clk_i  (clk_i),
      .en_i   (bank_en),
      .we_i   (m_we),
      .addr_i (m_addr),
      .wdata_i(m_wdata),
      .rdata_o(rdata_raw[b])
    );
  end

  always_comb begin
    idx_d = idx_q;
    off_d = off_q;
    rem_d = rem_q;
    clr_d = clr_q;
    if (cmd_i.fetch_clr) begin
      idx_d = '0;
    end else if (cmd_i.acc == bmfc_pkg::ACC_FETCH) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.walk_init) begin
      rem_d = len;
      off_d = (op_kind == bmfc_pkg::OPK_BWD) ? len - 1'b1 : '0;
    end else if (cmd_i.walk_step) begin
      rem_d = rem_q - 1'b1;
      off_d = (op_kind == bmfc_pkg::OPK_BWD) ? off_q - 1'b1 : off_q + 1'b1;
    end
    if (cmd_i.acc == bmfc_pkg::ACC_CLEAR) begin
      clr_d = clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      off_q    <= '0;
      rem_q    <= '0;
      clr_q    <= '0;
      rd_ok_q  <= 1'b0;
      rd_sel_q <= '0;
    end else begin
      idx_q <= idx_d;
      off_q <= off_d;
      rem_q <= rem_d;
      clr_q <= clr_d;
      if (m_en && !m_we) begin
        rd_ok_q  <= m_bank_ok;
        rd_sel_q <= m_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) begin
      op_q    <= item_i[bmfc_pkg::OPCODE_LSB +: bmfc_pkg::OPCODE_W];
      bank_q  <= item_i[bmfc_pkg::BANK_LSB +: bmfc_pkg::ITEM_BANK_W];
      addr_q  <= item_i[bmfc_pkg::ADDR_LSB +: AW];
      wdata_q <= item_i[bmfc_pkg::WDATA_LSB +: BW];
    end
    if ((cmd_i.acc == bmfc_pkg::ACC_FETCH) && (idx_q != '0)) begin
      hdr_q[idx_q - 1'b1] <= rdata;
    end
    if (cmd_i.res_ld) begin
      res_data_q <= (bmfc_pkg::item_op_e'(op_q) == bmfc_pkg::OPC_READ) ? rdata : '0;
      res_bad_q  <= (bmfc_pkg::item_op_e'(op_q) == bmfc_pkg::OPC_RUN) &&
                    (op_kind == bmfc_pkg::OPK_BAD);
    end
  end

  assign sts_o.clr_last   = (clr_q == '1);
  assign sts_o.fetch_last = (idx_q == bmfc_pkg::IDX_W'(bmfc_pkg::HDR_BYTES));
  assign sts_o.rem_zero   = (rem_q == '0);
  assign sts_o.op_kind    = op_kind;
  assign sts_o.item_op    = bmfc_pkg::item_op_e'(op_q);

  assign read_data_o   = res_data_q;
  assign bad_command_o = res_bad_q;

endmodule
`default_nettype wire

// ----- rtl/bmfc_ctrl.sv -----
// controller state machine for the banked memory fill and copy engine
`default_nettype none
module bmfc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire bmfc_pkg::ctrl_sts_t sts_i,
  output bmfc_pkg::ctrl_cmd_t      cmd_o
);

  bmfc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic res_free;

  assign res_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmfc_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = bmfc_pkg::S_IDLE;
      end
      bmfc_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bmfc_pkg::S_EXEC;
      end
      bmfc_pkg::S_EXEC: begin
        unique case (sts_i.item_op)
          bmfc_pkg::OPC_RUN: state_d = bmfc_pkg::S_FETCH;
          default:           state_d = bmfc_pkg::S_FINISH;
        endcase
      end
      bmfc_pkg::S_FETCH: begin
        if (sts_i.fetch_last) state_d = bmfc_pkg::S_DISPATCH;
      end
      bmfc_pkg::S_DISPATCH: begin
        unique case (sts_i.op_kind)
          bmfc_pkg::OPK_FILL: state_d = bmfc_pkg::S_FILL;
          bmfc_pkg::OPK_BAD:  state_d = bmfc_pkg::S_FINISH;
          default:            state_d = bmfc_pkg::S_CP_RD;
        endcase
      end
      bmfc_pkg::S_FILL: begin
        if (sts_i.rem_zero) state_d = bmfc_pkg::S_FINISH;
      end
      bmfc_pkg::S_CP_RD: begin
        state_d = sts_i.rem_zero ? bmfc_pkg::S_FINISH : bmfc_pkg::S_CP_WR;
      end
      bmfc_pkg::S_CP_WR: begin
        state_d = bmfc_pkg::S_CP_RD;
      end
      bmfc_pkg::S_FINISH: begin
        if (res_free) state_d = bmfc_pkg::S_IDLE;
      end
      default: state_d = bmfc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.acc   = bmfc_pkg::ACC_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      bmfc_pkg::S_CLEAR: begin
        cmd_o.acc = bmfc_pkg::ACC_CLEAR;
      end
      bmfc_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.item_ld = in_valid_i;
      end
      bmfc_pkg::S_EXEC: begin
        unique case (sts_i.item_op)
          bmfc_pkg::OPC_WRITE: cmd_o.acc = bmfc_pkg::ACC_ITEM_WR;
          bmfc_pkg::OPC_READ:  cmd_o.acc = bmfc_pkg::ACC_ITEM_RD;
          bmfc_pkg::OPC_RUN:   cmd_o.fetch_clr = 1'b1;
          default:             cmd_o.acc = bmfc_pkg::ACC_NONE;
        endcase
      end
      bmfc_pkg::S_FETCH: begin
        cmd_o.acc = bmfc_pkg::ACC_FETCH;
      end
      bmfc_pkg::S_DISPATCH: begin
        cmd_o.walk_init = (sts_i.op_kind != bmfc_pkg::OPK_BAD);
      end
      bmfc_pkg::S_FILL: begin
        if (!sts_i.rem_zero) begin
          cmd_o.acc       = bmfc_pkg::ACC_FILL_WR;
          cmd_o.walk_step = 1'b1;
        end
      end
      bmfc_pkg::S_CP_RD: begin
        if (!sts_i.rem_zero) cmd_o.acc = bmfc_pkg::ACC_SRC_RD;
      end
      bmfc_pkg::S_CP_WR: begin
        cmd_o.acc       = bmfc_pkg::ACC_DST_WR;
        cmd_o.walk_step = 1'b1;
      end
      bmfc_pkg::S_FINISH: begin
        if (res_free) begin
          cmd_o.res_ld = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmfc_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/banked_memory_fill_copy_engine_top.sv -----
// top level of the banked memory fill and copy engine
`default_nettype none
// After reset the engine zeroes its memory, one address of every bank per cycle,
// before it takes its first word. The bank rams are single-port with registered
// read. A byte write, a byte read or an unused opcode passes from acceptance
// through an execute state and a finish state to its result. A run command fetches
// and decodes the 11-byte command block, then for a fill writes the fill byte to each
// address in turn, or for a copy does one read then one write on the bank port for
// each byte, and then passes to its result. A finished result sits in an output
// register, and the next word is accepted while it waits.
module banked_memory_fill_copy_engine_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // opcode[1:0], bank[5:2], address[21:6], write_data[29:22], zero pad
  input  wire logic [bmfc_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // read_data[7:0], bad_command[8], zero pad
  output logic      [bmfc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  bmfc_pkg::ctrl_cmd_t cmd;
  bmfc_pkg::ctrl_sts_t sts;
  logic [bmfc_pkg::BYTE_W-1:0] read_data;
  logic                        bad_command;

  bmfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmfc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .item_i       (s_axis_tdata_i),
    .read_data_o  (read_data),
    .bad_command_o(bad_command)
  );

  assign m_axis_tdata_o = bmfc_pkg::OUT_TDATA_W'({bad_command, read_data});

endmodule
`default_nettype wire

// ----- sim/banked_memory_fill_copy_engine_checker.sv -----
// checker that mirrors the banked memory and compares every result word of the engine
module banked_memory_fill_copy_engine_checker
  import bmfc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_ready_i,
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_ready_i,
  input  wire logic [OUT_TDATA_W-1:0] out_data_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 owed_count_o
);

  typedef struct packed {
    logic              bad_command;
    logic [BYTE_W-1:0] read_data;
  } reply_t;

  bit [BYTE_W-1:0] shadow_mem [BANK_COUNT][BANK_BYTES];
  reply_t          owed_replies [$];
  reply_t          seen_reply;
  reply_t          owed_reply;

  function automatic logic [BYTE_W-1:0] peek_byte(int unsigned bank, logic [ADDR_W-1:0] addr);
    if (bank >= BANK_COUNT) return '0;
    return shadow_mem[bank][addr];
  endfunction

  function automatic void poke_byte(int unsigned bank, logic [ADDR_W-1:0] addr,
                                    logic [BYTE_W-1:0] value);
    if (bank < BANK_COUNT) shadow_mem[bank][addr] = value;
  endfunction

  // big-endian word from bank 0
  function automatic logic [WORD_W-1:0] block_word(logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] next_addr;
    next_addr = addr + 1'b1;
    return {peek_byte(0, addr), peek_byte(0, next_addr)};
  endfunction

  // returns 0 when the operation byte is unknown
  function automatic logic run_block(logic [ADDR_W-1:0] base);
    logic [BYTE_W-1:0] op;
    logic [BYTE_W-1:0] fill_value;
    logic [ADDR_W-1:0] span_addr;
    logic [ADDR_W-1:0] sink_addr;
    int unsigned       len;
    int unsigned       span_bank;
    int unsigned       sink_bank;
    int unsigned       i;
    op = peek_byte(0, base);
    if (op > CMD_COPY_BWD) return 1'b0;
    len       = block_word(ADDR_W'(base + HDR_LEN));
    span_bank = block_word(ADDR_W'(base + HDR_W3));
    span_addr = block_word(ADDR_W'(base + HDR_W5));
    if (op == CMD_FILL) begin
      fill_value = peek_byte(0, ADDR_W'(base + HDR_W7));
      for (i = 0; i < len; i++) poke_byte(span_bank, ADDR_W'(span_addr + i), fill_value);
    end else begin
      sink_bank = block_word(ADDR_W'(base + HDR_W7));
      sink_addr = block_word(ADDR_W'(base + HDR_W9));
      if (op == CMD_COPY_FWD) begin
        for (i = 0; i < len; i++)
          poke_byte(sink_bank, ADDR_W'(sink_addr + i),
                    peek_byte(span_bank, ADDR_W'(span_addr + i)));
      end else begin
        for (i = len; i > 0; i--)
          poke_byte(sink_bank, ADDR_W'(sink_addr + i - 1),
                    peek_byte(span_bank, ADDR_W'(span_addr + i - 1)));
      end
    end
    return 1'b1;
  endfunction

  function automatic reply_t apply_item(logic [IN_TDATA_W-1:0] word);
    item_op_e               op;
    logic [ITEM_BANK_W-1:0] bank;
    logic [ADDR_W-1:0]      addr;
    logic [BYTE_W-1:0]      wdata;
    reply_t                 reply;
    op    = item_op_e'(word[OPCODE_LSB +: OPCODE_W]);
    bank  = word[BANK_LSB +: ITEM_BANK_W];
    addr  = word[ADDR_LSB +: ADDR_W];
    wdata = word[WDATA_LSB +: BYTE_W];
    reply = '0;
    case (op)
      OPC_WRITE: poke_byte(bank, addr, wdata);
      OPC_READ:  reply.read_data = peek_byte(bank, addr);
      OPC_RUN:   reply.bad_command = !run_block(addr);
      default:   ;
    endcase
    return reply;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // drain before fill so a stray word never consumes a fresh prediction
      if (out_valid_i && out_ready_i) begin
        seen_reply = reply_t'(out_data_i[OUT_USED_W-1:0]);
        if (owed_replies.size() == 0) begin
          $error("result word with nothing outstanding: %h", out_data_i);
          mismatch_count_o++;
        end else begin
          owed_reply = owed_replies.pop_front();
          if (seen_reply.read_data !== owed_reply.read_data) begin
            $error("read_data: expected %h, actual %h", owed_reply.read_data,
                   seen_reply.read_data);
            mismatch_count_o++;
          end
          if (seen_reply.bad_command !== owed_reply.bad_command) begin
            $error("bad_command: expected %b, actual %b", owed_reply.bad_command,
                   seen_reply.bad_command);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) owed_replies.push_back(apply_item(in_data_i));
      owed_count_o = owed_replies.size();
    end
  end

endmodule

// ----- sim/banked_memory_fill_copy_engine_top_tb.sv -----
// testbench top: clock, reset, stimulus and verdict for the banked memory fill and copy engine
module banked_memory_fill_copy_engine_top_tb;
  import bmfc_pkg::*;

  localparam int unsigned     ITEM_TARGET  = 1850;
  localparam int unsigned     CALM_ITEMS   = 150;
  localparam int unsigned     LONG_HOLD    = 400;
  localparam int unsigned     DRAIN_CYCLES = 50;
  localparam longint unsigned CYCLE_LIMIT  = 6000000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [IN_TDATA_W-1:0]  in_data;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_TDATA_W-1:0] out_data;
  int unsigned            mismatch_count;
  int unsigned            owed_count;
  int unsigned            words_sent;
  longint unsigned        cycle_count;
  bit                     calm;
  bit                     hold_request;

  banked_memory_fill_copy_engine_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  banked_memory_fill_copy_engine_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .owed_count_o     (owed_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_item(item_op_e op, logic [ITEM_BANK_W-1:0] bank,
                           logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] value);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[OPCODE_LSB +: OPCODE_W]   = op;
    word[BANK_LSB +: ITEM_BANK_W]  = bank;
    word[ADDR_LSB +: ADDR_W]       = addr;
    word[WDATA_LSB +: BYTE_W]      = value;
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    calm = (words_sent + CALM_ITEMS >= ITEM_TARGET);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // fields: word 0 length in the low bits, then the words at offsets 3, 5, 7 and 9
  task automatic place_block(logic [ADDR_W-1:0] base, logic [BYTE_W-1:0] op,
                             logic [5*WORD_W-1:0] fields);
    logic [WORD_W-1:0] field;
    logic [BYTE_W-1:0] block_byte;
    int unsigned       k;
    for (k = 0; k < HDR_BYTES; k++) begin
      if (k == HDR_OP) begin
        block_byte = op;
      end else begin
        field = fields[((k - 1) / 2) * WORD_W +: WORD_W];
        block_byte = ((k - 1) % 2 == 0) ? field[WORD_W-1 -: BYTE_W] : field[BYTE_W-1:0];
      end
      send_item(OPC_WRITE, '0, ADDR_W'(base + k), block_byte);
    end
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return ADDR_W'(16'hFFF0 + $urandom_range(0, 15));
      1:       return ADDR_W'($urandom_range(0, 63));
      2:       return ADDR_W'(16'h4000 + $urandom_range(0, 255));
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  function automatic logic [ITEM_BANK_W-1:0] pick_bank();
    case ($urandom_range(0, 3))
      0, 1:    return ITEM_BANK_W'($urandom_range(0, 3));
      2:       return ITEM_BANK_W'(BANK_COUNT - 1);
      default: return ITEM_BANK_W'($urandom);
    endcase
  endfunction

  // banks named in a command block may lie past the last bank
  function automatic logic [WORD_W-1:0] pick_block_bank();
    case ($urandom_range(0, 9))
      0:       return WORD_W'($urandom);
      1:       return WORD_W'(BANK_COUNT);
      default: return WORD_W'(pick_bank());
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return WORD_W'($urandom_range(1000, 65535));
    if (roll < 8) return '0;
    if (roll < 25) return WORD_W'($urandom_range(25, 300));
    return WORD_W'($urandom_range(1, 24));
  endfunction

  task automatic run_sequence();
    logic [BYTE_W-1:0]      op;
    logic [ADDR_W-1:0]      base;
    logic [ADDR_W-1:0]      span_addr;
    logic [ADDR_W-1:0]      sink_addr;
    logic [ADDR_W-1:0]      probe_addr;
    logic [WORD_W-1:0]      len;
    logic [WORD_W-1:0]      span_bank;
    logic [WORD_W-1:0]      sink_bank;
    logic [WORD_W-1:0]      probe_bank;
    case ($urandom_range(0, 9))
      0, 1, 2: op = CMD_FILL;
      3, 4, 5: op = CMD_COPY_FWD;
      6, 7, 8: op = CMD_COPY_BWD;
      default: op = CMD_COPY_BWD + BYTE_W'($urandom_range(1, 255 - CMD_COPY_BWD));
    endcase
    // some blocks straddle the top of bank 0
    if ($urandom_range(0, 7) == 0) base = ADDR_W'(16'hFFF5 + $urandom_range(0, 10));
    else base = ADDR_W'(16'h8000 + $urandom_range(0, 16'h0FFF));
    len       = pick_len();
    span_bank = pick_block_bank();
    span_addr = pick_addr();
    sink_bank = (op == CMD_FILL) ? WORD_W'($urandom) : pick_block_bank();
    sink_addr = pick_addr();
    place_block(base, op, {WORD_W'(sink_addr), sink_bank, WORD_W'(span_addr), span_bank, len});
    send_item(OPC_RUN, ITEM_BANK_W'($urandom), base, BYTE_W'($urandom));
    if (op == CMD_FILL) begin
      probe_bank = span_bank;
      probe_addr = span_addr;
    end else begin
      probe_bank = sink_bank;
      probe_addr = sink_addr;
    end
    repeat ($urandom_range(1, 4))
      send_item(OPC_READ, probe_bank[ITEM_BANK_W-1:0],
                ADDR_W'(probe_addr + $urandom_range(0, len)), BYTE_W'($urandom));
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 5))
      0, 1: send_item(OPC_WRITE, pick_bank(), pick_addr(), BYTE_W'($urandom));
      2, 3: send_item(OPC_READ, pick_bank(), pick_addr(), BYTE_W'($urandom));
      4:    send_item(OPC_NONE, ITEM_BANK_W'($urandom), ADDR_W'($urandom), BYTE_W'($urandom));
      default:
        send_item(OPC_RUN, ITEM_BANK_W'($urandom),
                  ADDR_W'(16'hA000 + $urandom_range(0, 16'h1FFF)), BYTE_W'($urandom));
    endcase
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OPC_WRITE, 4'hF, 16'hFFFF, 8'hFF);
    send_item(OPC_READ, 4'hF, 16'hFFFF, 8'h00);
    send_item(OPC_WRITE, 4'h0, 16'h0000, 8'h00);
    send_item(OPC_READ, 4'h0, 16'h0000, 8'hFF);
    send_item(OPC_NONE, 4'hF, 16'hFFFF, 8'hFF);
    // untouched block: fill with zero length
    send_item(OPC_RUN, 4'h0, 16'h9000, 8'h00);
    // unknown operation byte
    send_item(OPC_WRITE, 4'h0, 16'h9100, 8'hFF);
    send_item(OPC_RUN, 4'h0, 16'h9100, 8'h00);
    // wrapped block, maximum-length fill that wraps around bank 1
    place_block(16'hFFFA, CMD_FILL, {16'h0000, 16'h5A00, 16'h8000, 16'h0001, 16'hFFFF});
    send_item(OPC_RUN, 4'hF, 16'hFFFA, 8'hFF);
    send_item(OPC_READ, 4'h1, 16'h7FFE, 8'h00);
    send_item(OPC_READ, 4'h1, 16'h7FFF, 8'h00);
    send_item(OPC_READ, 4'h1, 16'h8000, 8'h00);

    hold_request = 1'b1;
    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0) run_sequence();
      else send_noise();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
